>>> design/ocu_pkg.sv
// ----------------------------------------------------------------------------
// Orbit camera update package
// Shared constants, types and helper functions for the orbit camera block.
// ----------------------------------------------------------------------------
package ocu_pkg;

   localparam int CORDIC_STEPS = 16;
   localparam int STEP_W       = $clog2(CORDIC_STEPS + 1);
   localparam int RED_STEPS    = 10;
   localparam int PROD_W       = 68;
   localparam int ANG_W        = 33;
   localparam int CS_W         = 34;
   localparam int Z_W          = 36;
   localparam int RED_W        = 35;

   typedef logic signed [PROD_W-1:0] prod_type;
   typedef logic signed [ANG_W-1:0]  ang_type;
   typedef logic signed [CS_W-1:0]   cs_type;
   typedef logic signed [Z_W-1:0]    z_type;
   typedef logic signed [31:0]       q16_type;

   localparam longint DEG360      = 64'sd23592960;
   localparam longint RED_BIAS    = 64'sd183 * DEG360;
   localparam longint Q24_90      = 64'sd90 <<< 24;
   localparam longint Q24_180     = 64'sd180 <<< 24;
   localparam longint Q24_360     = 64'sd360 <<< 24;
   localparam longint CORDIC_GAIN = 64'sd652032874;
   localparam longint RAD_TO_DEG  = 64'sd961263669;
   localparam longint PITCH_MAX   = 64'sd5898240;
   localparam longint YAW_BASE    = 64'sd11796480;
   localparam longint DIST_RESET  = 64'sd3276800;
   localparam longint DY_SCALE    = 64'sd6554;
   localparam longint DX_SCALE    = 64'sd19661;

   localparam longint ATAN_LOW [11] = '{
      64'sd754974720, 64'sd445687602, 64'sd235489088, 64'sd119537938,
      64'sd60000934, 64'sd30029717, 64'sd15018523, 64'sd7509719,
      64'sd3754917, 64'sd1877466, 64'sd938734
   };

   localparam logic CSR_CAP_PITCH = 1'b0;
   localparam logic CSR_ZOOM_STEP = 1'b1;

   typedef enum logic [4:0] {
      ST_IDLE, ST_ZMUL, ST_ZAPP, ST_PMUL, ST_PAPP, ST_AMUL, ST_AAPP,
      ST_SC1, ST_SC1W, ST_HMUL, ST_HSTO, ST_VMUL, ST_VSTO,
      ST_SC2, ST_SC2W, ST_XMUL, ST_XSTO, ST_CMUL, ST_CSTO, ST_OUT
   } state_type;

   typedef enum logic [2:0] {
      SC_IDLE, SC_REDUCE, SC_FOLD, SC_ROTATE, SC_DONE
   } sc_state_type;

   typedef struct packed {
      logic    start;
      ang_type angle;
   } sc_cmd_type;

   typedef struct packed {
      logic    done;
      q16_type sin;
      q16_type cos;
   } sc_res_type;

   // rotation angle of one step, degrees in Q24
   function automatic z_type atan_step(input logic [STEP_W-1:0] i);
      longint t;
      t = 0;
      if (i < STEP_W'(11)) begin
         t = ATAN_LOW[i[3:0]];
      end else begin
         t = (RAD_TO_DEG + (64'sd1 <<< (int'(i) - 1))) >>> int'(i);
      end
      return z_type'(t);
   endfunction

   function automatic q16_type sat32(input prod_type v);
      q16_type r;
      r = v[31:0];
      if (v > prod_type'(64'sd2147483647)) begin
         r = 32'sh7fffffff;
      end else if (v < prod_type'(-64'sd2147483648)) begin
         r = 32'sh80000000;
      end
      return r;
   endfunction

endpackage

>>> design/ocu_req_if.sv
// ----------------------------------------------------------------------------
// Orbit camera request channel
// Valid/ready channel carrying one frame of camera input.
// ----------------------------------------------------------------------------
interface ocu_req_if;
   logic              valid;
   logic              ready;
   logic              zoom_req;
   logic              move_req;
   logic signed [7:0] scroll_steps;
   logic signed [31:0] mouse_dx;
   logic signed [31:0] mouse_dy;
   logic signed [31:0] player_x;
   logic signed [31:0] player_y;
   logic signed [31:0] player_z;
   logic signed [31:0] player_yaw;

   modport source (output valid, zoom_req, move_req, scroll_steps, mouse_dx, mouse_dy,
                   player_x, player_y, player_z, player_yaw, input ready);
   modport sink (input valid, zoom_req, move_req, scroll_steps, mouse_dx, mouse_dy,
                 player_x, player_y, player_z, player_yaw, output ready);
endinterface

>>> design/ocu_rsp_if.sv
// ----------------------------------------------------------------------------
// Orbit camera response channel
// Valid/ready channel carrying the camera position and orientation.
// ----------------------------------------------------------------------------
interface ocu_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] cam_x;
   logic signed [31:0] cam_y;
   logic signed [31:0] cam_z;
   logic signed [31:0] cam_pitch;
   logic signed [31:0] cam_yaw;

   modport source (output valid, cam_x, cam_y, cam_z, cam_pitch, cam_yaw, input ready);
   modport sink (input valid, cam_x, cam_y, cam_z, cam_pitch, cam_yaw, output ready);
endinterface

>>> design/ocu_csr_if.sv
// ----------------------------------------------------------------------------
// Orbit camera register write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface ocu_csr_if;
   logic        valid;
   logic        ready;
   logic        index;
   logic [31:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

>>> design/ocu_sincos.sv
// ----------------------------------------------------------------------------
// Orbit camera sine/cosine unit
// Iterative modulo-360 reduction, quadrant fold and CORDIC rotation.
// ----------------------------------------------------------------------------
module ocu_sincos (
   input  logic                clock,
   input  logic                reset,
   input  ocu_pkg::sc_cmd_type cmd,
   output ocu_pkg::sc_res_type res
);

   ocu_pkg::sc_state_type              state_ff, state_in;
   logic [ocu_pkg::STEP_W-1:0]         cnt_ff, cnt_in;
   logic [ocu_pkg::RED_W-1:0]          u_ff, u_in;
   ocu_pkg::cs_type                    x_ff, x_in, y_ff, y_in;
   ocu_pkg::z_type                     z_ff, z_in;
   logic                               negc_ff, negc_in;
   ocu_pkg::z_type                     start_sum, trial, zf, zw;
   ocu_pkg::cs_type                    xs, ys, xo;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ocu_pkg::SC_IDLE;
      end else begin
         state_ff <= state_in;
      end
      cnt_ff  <= cnt_in;
      u_ff    <= u_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      negc_ff <= negc_in;
   end

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      u_in      = u_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      z_in      = z_ff;
      negc_in   = negc_ff;
      start_sum = ocu_pkg::z_type'(cmd.angle) + ocu_pkg::z_type'(ocu_pkg::RED_BIAS);
      trial     = ocu_pkg::z_type'({1'b0, u_ff})
                - (ocu_pkg::z_type'(ocu_pkg::DEG360) <<< cnt_ff);
      zf        = ocu_pkg::z_type'({1'b0, u_ff}) <<< 8;
      zw        = zf;
      xs        = x_ff >>> cnt_ff;
      ys        = y_ff >>> cnt_ff;
      unique case (state_ff)
         ocu_pkg::SC_IDLE: begin
            if (cmd.start) begin
               u_in     = start_sum[ocu_pkg::RED_W-1:0];
               cnt_in   = ocu_pkg::STEP_W'(ocu_pkg::RED_STEPS - 1);
               state_in = ocu_pkg::SC_REDUCE;
            end
         end
         ocu_pkg::SC_REDUCE: begin
            // restoring subtract of 360 degrees times a power of two
            if (!trial[ocu_pkg::Z_W-1]) begin
               u_in = trial[ocu_pkg::RED_W-1:0];
            end
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = ocu_pkg::SC_FOLD;
            end
         end
         ocu_pkg::SC_FOLD: begin
            if (zf > ocu_pkg::z_type'(ocu_pkg::Q24_180)) begin
               zw = zf - ocu_pkg::z_type'(ocu_pkg::Q24_360);
            end
            negc_in = 1'b0;
            z_in    = zw;
            if (zw > ocu_pkg::z_type'(ocu_pkg::Q24_90)) begin
               z_in    = ocu_pkg::z_type'(ocu_pkg::Q24_180) - zw;
               negc_in = 1'b1;
            end else if (zw < -ocu_pkg::z_type'(ocu_pkg::Q24_90)) begin
               z_in    = -ocu_pkg::z_type'(ocu_pkg::Q24_180) - zw;
               negc_in = 1'b1;
            end
            x_in     = ocu_pkg::cs_type'(ocu_pkg::CORDIC_GAIN);
            y_in     = '0;
            cnt_in   = '0;
            state_in = ocu_pkg::SC_ROTATE;
         end
         ocu_pkg::SC_ROTATE: begin
            if (!z_ff[ocu_pkg::Z_W-1]) begin
               x_in = x_ff - ys;
               y_in = y_ff + xs;
               z_in = z_ff - ocu_pkg::atan_step(cnt_ff);
            end else begin
               x_in = x_ff + ys;
               y_in = y_ff - xs;
               z_in = z_ff + ocu_pkg::atan_step(cnt_ff);
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == ocu_pkg::STEP_W'(ocu_pkg::CORDIC_STEPS - 1)) begin
               state_in = ocu_pkg::SC_DONE;
            end
         end
         ocu_pkg::SC_DONE: begin
            state_in = ocu_pkg::SC_IDLE;
         end
         default: begin
            state_in = ocu_pkg::SC_IDLE;
         end
      endcase
   end

   assign xo       = negc_ff ? -x_ff : x_ff;
   assign res.done = (state_ff == ocu_pkg::SC_DONE);
   assign res.sin  = y_ff[31:0];
   assign res.cos  = xo[31:0];

endmodule

>>> design/orbit_camera_update_unit.sv
// ----------------------------------------------------------------------------
// Orbit camera update unit
// Per-frame zoom, pitch and orbit update, then camera placement around the
// player from a shared multiplier and an iterative sine/cosine unit.
//
//   channel   role    transfer carries
//   req_ch    sink    zoom/move flags, scroll, mouse deltas, player pose
//   rsp_ch    source  camera x/y/z, pitch, yaw
//   csr_ch    sink    register index, write data (always ready)
//
// Between accept and result an item takes two sine/cosine runs (10 reduction
// steps, fold, 16 CORDIC steps, done) plus seven passes through the one
// registered 34x34 multiplier.
// The next item is accepted as soon as the sequencer is back in idle, even
// while the previous result still waits for rsp_ch.ready.
// Synchronous reset sets distance to 50.0, pitch and orbit angle to zero.
// ----------------------------------------------------------------------------
module orbit_camera_update_unit (
   input  logic      clock,
   input  logic      reset,
   ocu_req_if.sink   req_ch,
   ocu_rsp_if.source rsp_ch,
   ocu_csr_if.sink   csr_ch
);

   ocu_pkg::state_type state_ff, state_in;
   logic               cap_pitch_ff, cap_pitch_in;
   logic [30:0]        zoom_step_ff, zoom_step_in;
   ocu_pkg::q16_type   distance_ff, distance_in, pitch_ff, pitch_in, orbit_ff, orbit_in;
   logic               zoom_req_ff, move_req_ff;
   logic signed [7:0]  scroll_ff;
   ocu_pkg::q16_type   dx_ff, dy_ff, px_ff, py_ff, pz_ff, yaw_ff;
   ocu_pkg::ang_type   theta_ff, theta_in;
   ocu_pkg::prod_type  prod_ff, prod_in, rnd30, dp, pnext;
   ocu_pkg::cs_type    mul_a, mul_b;
   ocu_pkg::q16_type   sp_ff, sp_in, cp_ff, cp_in, st_ff, st_in, ct_ff, ct_in;
   ocu_pkg::cs_type    hd_ff, hd_in, vd_ff, vd_in;
   ocu_pkg::q16_type   camx_ff, camx_in, camz_ff, camz_in, ptmp;
   logic               rsp_valid_ff, rsp_valid_in;
   ocu_pkg::q16_type   rx_ff, rx_in, ry_ff, ry_in, rz_ff, rz_in, rp_ff, rp_in, rw_ff, rw_in;
   ocu_pkg::sc_cmd_type sc_cmd;
   ocu_pkg::sc_res_type sc_res;

   ocu_sincos u_sincos (
      .clock (clock),
      .reset (reset),
      .cmd   (sc_cmd),
      .res   (sc_res)
   );

   assign req_ch.ready     = (state_ff == ocu_pkg::ST_IDLE);
   assign csr_ch.ready     = 1'b1;
   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.cam_x     = rx_ff;
   assign rsp_ch.cam_y     = ry_ff;
   assign rsp_ch.cam_z     = rz_ff;
   assign rsp_ch.cam_pitch = rp_ff;
   assign rsp_ch.cam_yaw   = rw_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ocu_pkg::ST_IDLE;
         cap_pitch_ff <= 1'b1;
         zoom_step_ff <= 31'd65536;
         distance_ff  <= ocu_pkg::q16_type'(ocu_pkg::DIST_RESET);
         pitch_ff     <= '0;
         orbit_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cap_pitch_ff <= cap_pitch_in;
         zoom_step_ff <= zoom_step_in;
         distance_ff  <= distance_in;
         pitch_ff     <= pitch_in;
         orbit_ff     <= orbit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (req_ch.valid && req_ch.ready) begin
         zoom_req_ff <= req_ch.zoom_req;
         move_req_ff <= req_ch.move_req;
         scroll_ff   <= req_ch.scroll_steps;
         dx_ff       <= req_ch.mouse_dx;
         dy_ff       <= req_ch.mouse_dy;
         px_ff       <= req_ch.player_x;
         py_ff       <= req_ch.player_y;
         pz_ff       <= req_ch.player_z;
         yaw_ff      <= req_ch.player_yaw;
      end
      theta_ff <= theta_in;
      prod_ff  <= prod_in;
      sp_ff    <= sp_in;
      cp_ff    <= cp_in;
      st_ff    <= st_in;
      ct_ff    <= ct_in;
      hd_ff    <= hd_in;
      vd_ff    <= vd_in;
      camx_ff  <= camx_in;
      camz_ff  <= camz_in;
      rx_ff    <= rx_in;
      ry_ff    <= ry_in;
      rz_ff    <= rz_in;
      rp_ff    <= rp_in;
      rw_ff    <= rw_in;
   end

   // register writes
   always_comb begin
      cap_pitch_in = cap_pitch_ff;
      zoom_step_in = zoom_step_ff;
      if (csr_ch.valid) begin
         unique case (csr_ch.index)
            ocu_pkg::CSR_CAP_PITCH: cap_pitch_in = csr_ch.data[0];
            ocu_pkg::CSR_ZOOM_STEP: zoom_step_in = csr_ch.data[30:0];
            default: ;
         endcase
      end
   end

   assign prod_in = ocu_pkg::prod_type'(mul_a) * ocu_pkg::prod_type'(mul_b);
   assign rnd30   = (prod_ff + (ocu_pkg::prod_type'(1) <<< 29)) >>> 30;
   assign dp      = (prod_ff + ocu_pkg::prod_type'(32768)) >>> 16;

   always_comb begin
      state_in     = state_ff;
      distance_in  = distance_ff;
      pitch_in     = pitch_ff;
      orbit_in     = orbit_ff;
      theta_in     = theta_ff;
      sp_in        = sp_ff;
      cp_in        = cp_ff;
      st_in        = st_ff;
      ct_in        = ct_ff;
      hd_in        = hd_ff;
      vd_in        = vd_ff;
      camx_in      = camx_ff;
      camz_in      = camz_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rx_in        = rx_ff;
      ry_in        = ry_ff;
      rz_in        = rz_ff;
      rp_in        = rp_ff;
      rw_in        = rw_ff;
      mul_a        = '0;
      mul_b        = '0;
      sc_cmd.start = 1'b0;
      sc_cmd.angle = theta_ff;
      pnext        = ocu_pkg::prod_type'(pitch_ff) - dp;
      ptmp         = ocu_pkg::sat32(pnext);
      unique case (state_ff)
         ocu_pkg::ST_IDLE: begin
            if (req_ch.valid) begin
               state_in = ocu_pkg::ST_ZMUL;
            end
         end
         ocu_pkg::ST_ZMUL: begin
            mul_a    = ocu_pkg::cs_type'(scroll_ff);
            mul_b    = ocu_pkg::cs_type'({1'b0, zoom_step_ff});
            state_in = ocu_pkg::ST_ZAPP;
         end
         ocu_pkg::ST_ZAPP: begin
            if (zoom_req_ff) begin
               distance_in = ocu_pkg::sat32(ocu_pkg::prod_type'(distance_ff) - prod_ff);
            end
            state_in = ocu_pkg::ST_PMUL;
         end
         ocu_pkg::ST_PMUL: begin
            mul_a    = ocu_pkg::cs_type'(dy_ff);
            mul_b    = ocu_pkg::cs_type'(ocu_pkg::DY_SCALE);
            state_in = ocu_pkg::ST_PAPP;
         end
         ocu_pkg::ST_PAPP: begin
            if (move_req_ff) begin
               pitch_in = ptmp;
               if (cap_pitch_ff) begin
                  if (ptmp < 0) begin
                     pitch_in = '0;
                  end else if (ptmp > ocu_pkg::q16_type'(ocu_pkg::PITCH_MAX)) begin
                     pitch_in = ocu_pkg::q16_type'(ocu_pkg::PITCH_MAX);
                  end
               end
            end
            state_in = ocu_pkg::ST_AMUL;
         end
         ocu_pkg::ST_AMUL: begin
            mul_a    = ocu_pkg::cs_type'(dx_ff);
            mul_b    = ocu_pkg::cs_type'(ocu_pkg::DX_SCALE);
            state_in = ocu_pkg::ST_AAPP;
         end
         ocu_pkg::ST_AAPP: begin
            if (move_req_ff) begin
               orbit_in = ocu_pkg::sat32(ocu_pkg::prod_type'(orbit_ff) - dp);
            end
            theta_in = ocu_pkg::ang_type'(yaw_ff) + ocu_pkg::ang_type'(orbit_in);
            state_in = ocu_pkg::ST_SC1;
         end
         ocu_pkg::ST_SC1: begin
            sc_cmd.start = 1'b1;
            sc_cmd.angle = ocu_pkg::ang_type'(pitch_ff);
            state_in     = ocu_pkg::ST_SC1W;
         end
         ocu_pkg::ST_SC1W: begin
            if (sc_res.done) begin
               sp_in    = sc_res.sin;
               cp_in    = sc_res.cos;
               state_in = ocu_pkg::ST_HMUL;
            end
         end
         ocu_pkg::ST_HMUL: begin
            mul_a    = ocu_pkg::cs_type'(distance_ff);
            mul_b    = ocu_pkg::cs_type'(cp_ff);
            state_in = ocu_pkg::ST_HSTO;
         end
         ocu_pkg::ST_HSTO: begin
            hd_in    = rnd30[ocu_pkg::CS_W-1:0];
            state_in = ocu_pkg::ST_VMUL;
         end
         ocu_pkg::ST_VMUL: begin
            mul_a    = ocu_pkg::cs_type'(distance_ff);
            mul_b    = ocu_pkg::cs_type'(sp_ff);
            state_in = ocu_pkg::ST_VSTO;
         end
         ocu_pkg::ST_VSTO: begin
            vd_in    = rnd30[ocu_pkg::CS_W-1:0];
            state_in = ocu_pkg::ST_SC2;
         end
         ocu_pkg::ST_SC2: begin
            sc_cmd.start = 1'b1;
            state_in     = ocu_pkg::ST_SC2W;
         end
         ocu_pkg::ST_SC2W: begin
            if (sc_res.done) begin
               st_in    = sc_res.sin;
               ct_in    = sc_res.cos;
               state_in = ocu_pkg::ST_XMUL;
            end
         end
         ocu_pkg::ST_XMUL: begin
            mul_a    = hd_ff;
            mul_b    = ocu_pkg::cs_type'(st_ff);
            state_in = ocu_pkg::ST_XSTO;
         end
         ocu_pkg::ST_XSTO: begin
            camx_in  = ocu_pkg::sat32(ocu_pkg::prod_type'(px_ff) - rnd30);
            state_in = ocu_pkg::ST_CMUL;
         end
         ocu_pkg::ST_CMUL: begin
            mul_a    = hd_ff;
            mul_b    = ocu_pkg::cs_type'(ct_ff);
            state_in = ocu_pkg::ST_CSTO;
         end
         ocu_pkg::ST_CSTO: begin
            camz_in  = ocu_pkg::sat32(ocu_pkg::prod_type'(pz_ff) - rnd30);
            state_in = ocu_pkg::ST_OUT;
         end
         ocu_pkg::ST_OUT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rx_in        = camx_ff;
               ry_in        = ocu_pkg::sat32(ocu_pkg::prod_type'(py_ff)
                                             + ocu_pkg::prod_type'(vd_ff));
               rz_in        = camz_ff;
               rp_in        = pitch_ff;
               rw_in        = ocu_pkg::sat32(ocu_pkg::prod_type'(ocu_pkg::YAW_BASE)
                                             - ocu_pkg::prod_type'(theta_ff));
               state_in     = ocu_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ocu_pkg::ST_IDLE;
         end
      endcase
   end

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> state_ff == ocu_pkg::ST_ZMUL)
      else $error("accepted item did not start the sequence");

   a_done_waited: assert property (@(posedge clock) disable iff (reset)
      sc_res.done |-> (state_ff == ocu_pkg::ST_SC1W || state_ff == ocu_pkg::ST_SC2W))
      else $error("sine/cosine result arrived while not waited for");

   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ocu_pkg::ST_OUT)
      else $error("result raised outside the output step");

endmodule
